@@ hdl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// Slider swipe detector package
// Shared beat types, event codes and register constants.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int unsigned PosWidth = 8;
    localparam int unsigned AddrWidth = 3;
    localparam int unsigned DataWidth = 32;

    localparam logic [PosWidth-1:0] ThresholdReset = 8'd20;
    localparam logic [AddrWidth-3:0] RegSwipeThreshold = 1'b0;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_SELECT      = 3'd1,
        KIND_BACK        = 3'd2,
        KIND_SWIPE_LEFT  = 3'd3,
        KIND_SWIPE_RIGHT = 3'd4
    } touch_kind_t;

    typedef struct packed {
        logic                sensor_busy;
        logic                select_active;
        logic                back_active;
        logic                slider_active;
        logic [PosWidth-1:0] slider_position;
    } scan_beat_t;

    typedef struct packed {
        touch_kind_t touch_kind;
        logic        busy_flag;
    } event_beat_t;

endpackage

@@ hdl/slider_swipe_detector.sv @@
// ----------------------------------------------------------------------------
// Slider swipe detector
// Turns touch-scan results into select, back and swipe events.
// ----------------------------------------------------------------------------
// Each scan beat on the s_ channel yields exactly one event beat on the m_
// channel. The slider state is updated, and the event is registered, at the
// clock edge that accepts the scan beat (into the skid register on a stall).
// One scan beat can be accepted in every cycle while the skid is empty.
// The event leaves through an output register backed by a one-entry skid
// register. When the receiver stalls, one more scan beat is taken into the
// skid register; s_ready then drops until the output register is emptied.
// Synchronous reset clears the slider state and both arming flags, empties
// the output stages and loads the swipe threshold with 20.
// The threshold is written through the APB-style port at byte address 0 and
// should only be changed while no events are outstanding. Reads return it.
// ----------------------------------------------------------------------------
module slider_swipe_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ssd_pkg::scan_beat_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ssd_pkg::event_beat_t                m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssd_pkg::AddrWidth-1:0]       paddr,
    input  logic [ssd_pkg::DataWidth-1:0]       pwdata,
    output logic [ssd_pkg::DataWidth-1:0]       prdata,
    output logic                                pready
);

    localparam int unsigned PW = ssd_pkg::PosWidth;

    logic [PW-1:0] threshold_reg;
    logic [PW-1:0] last_pos_reg, last_pos_next;
    logic [PW-1:0] right_sum_reg, right_sum_next;
    logic [PW-1:0] left_sum_reg, left_sum_next;
    logic          held_reg, held_next;
    logic          right_armed_reg, right_armed_next;
    logic          left_armed_reg, left_armed_next;

    ssd_pkg::event_beat_t out_reg, out_next;
    ssd_pkg::event_beat_t skid_reg;
    ssd_pkg::event_beat_t result;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    logic          accept;
    logic          out_load;
    logic          cfg_write;
    logic [PW-1:0] right_add;
    logic [PW-1:0] left_add;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ssd_pkg::AddrWidth-1:2] == ssd_pkg::RegSwipeThreshold);
    assign prdata    = (paddr[ssd_pkg::AddrWidth-1:2] == ssd_pkg::RegSwipeThreshold)
                       ? {{(ssd_pkg::DataWidth-PW){1'b0}}, threshold_reg}
                       : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ssd_pkg::ThresholdReset;
        end else if (cfg_write) begin
            threshold_reg <= pwdata[PW-1:0];
        end
    end

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_load = m_ready || !out_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign right_add = right_sum_reg + (s_data.slider_position - last_pos_reg);
    assign left_add  = left_sum_reg + (last_pos_reg - s_data.slider_position);

    always_comb begin
        last_pos_next     = last_pos_reg;
        right_sum_next    = right_sum_reg;
        left_sum_next     = left_sum_reg;
        held_next         = held_reg;
        right_armed_next  = right_armed_reg;
        left_armed_next   = left_armed_reg;
        result.touch_kind = ssd_pkg::KIND_NONE;
        result.busy_flag  = 1'b0;
        priority if (s_data.sensor_busy) begin
            result.busy_flag = 1'b1;
        end else if (s_data.select_active) begin
            result.touch_kind = ssd_pkg::KIND_SELECT;
        end else if (s_data.back_active) begin
            result.touch_kind = ssd_pkg::KIND_BACK;
        end else if (s_data.slider_active) begin
            last_pos_next = s_data.slider_position;
            if (!held_reg) begin
                right_sum_next   = '0;
                left_sum_next    = '0;
                held_next        = 1'b1;
                right_armed_next = 1'b1;
                left_armed_next  = 1'b1;
            end else if (s_data.slider_position > last_pos_reg) begin
                left_sum_next = '0;
                if (right_add > threshold_reg) begin
                    right_sum_next = '0;
                    if (right_armed_reg) begin
                        result.touch_kind = ssd_pkg::KIND_SWIPE_RIGHT;
                        right_armed_next  = 1'b0;
                    end else begin
                        left_armed_next = 1'b1;
                    end
                end else begin
                    right_sum_next = right_add;
                end
            end else if (s_data.slider_position < last_pos_reg) begin
                right_sum_next = '0;
                if (left_add > threshold_reg) begin
                    left_sum_next = '0;
                    if (left_armed_reg) begin
                        result.touch_kind = ssd_pkg::KIND_SWIPE_LEFT;
                        left_armed_next   = 1'b0;
                    end else begin
                        right_armed_next = 1'b1;
                    end
                end else begin
                    left_sum_next = left_add;
                end
            end
        end else begin
            held_next      = 1'b0;
            right_sum_next = '0;
            left_sum_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg    <= '0;
            right_sum_reg   <= '0;
            left_sum_reg    <= '0;
            held_reg        <= 1'b0;
            right_armed_reg <= 1'b0;
            left_armed_reg  <= 1'b0;
        end else if (accept) begin
            last_pos_reg    <= last_pos_next;
            right_sum_reg   <= right_sum_next;
            left_sum_reg    <= left_sum_next;
            held_reg        <= held_next;
            right_armed_reg <= right_armed_next;
            left_armed_reg  <= left_armed_next;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load) begin
            out_valid_next  = skid_valid_reg || accept;
            out_next        = skid_valid_reg ? skid_reg : result;
            skid_valid_next = skid_valid_reg && accept;
        end else if (accept) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (accept && (!out_load || skid_valid_reg)) begin
            skid_reg <= result;
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a beat while the output register is empty.");

    a_one_sum_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (right_sum_reg == '0) || (left_sum_reg == '0))
        else $error("Both travel sums are nonzero.");

    a_busy_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.sensor_busy) |=>
            ($stable(right_sum_reg) && $stable(left_sum_reg) && $stable(held_reg)
             && $stable(last_pos_reg)))
        else $error("Slider state changed on a busy scan.");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.sensor_busy && !s_data.select_active && !s_data.back_active
         && !s_data.slider_active) |=>
            (!held_reg && (right_sum_reg == '0) && (left_sum_reg == '0)))
        else $error("Release did not clear the slider state.");

    a_busy_event_is_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.busy_flag) |-> (m_data.touch_kind == ssd_pkg::KIND_NONE))
        else $error("Busy event carries a touch kind.");

endmodule
